// File: hw/rtl/rdbf_pkg.sv
// ----------------------------------------------------------------------------
// rdbf_pkg
// shared types and constants of the round dab blending framebuffer
// ----------------------------------------------------------------------------
`default_nettype none
package rdbf_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int PIX_W          = 24;
  localparam int DIM_W          = 9;
  localparam int CFG_AW         = 3;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_DAB     = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  localparam logic [CFG_AW-1:0] ADDR_WIDTH  = 3'h0;
  localparam logic [CFG_AW-1:0] ADDR_HEIGHT = 3'h4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [11:0]        dab_radius;
    logic [8:0]         opacity;
    logic [7:0]         brush_red;
    logic [7:0]         brush_green;
    logic [7:0]         brush_blue;
    logic [7:0]         pixel_x;
    logic [7:0]         pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_red;
    logic [7:0] read_green;
    logic [7:0] read_blue;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture command, compute box
    logic walk;     // present current pixel to memory
    logic step;     // advance scan position
    logic rd;       // issue single read
    logic rd_done;  // drive result
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic box_empty;
    logic last;
  } sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/rdbf_ram.sv
// ----------------------------------------------------------------------------
// rdbf_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module rdbf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/rdbf_ctrl.sv
// ----------------------------------------------------------------------------
// rdbf_ctrl
// command sequencer of the framebuffer
// ----------------------------------------------------------------------------
`default_nettype none
module rdbf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [1:0]    cmd,
  input  wire rdbf_pkg::sts_t sts,
  output logic               busy,
  output rdbf_pkg::ctl_t     ctl
);
  import rdbf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_WALK  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_READ  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] drain_r, drain_nxt;
  logic       rd_r, rd_nxt;
  logic       fin_r, fin_nxt;

  always_comb begin
    state_nxt = state_r;
    drain_nxt = drain_r;
    rd_nxt    = 1'b0;
    fin_nxt   = 1'b0;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        // no new command while the result of the last one is out
        if (start && !fin_r) begin
          ctl.load = 1'b1;
          if (cmd == CMD_READ) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        if (sts.box_empty) begin
          state_nxt = S_DRAIN;
          drain_nxt = 2'd0;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        ctl.walk = 1'b1;
        ctl.step = 1'b1;
        if (sts.last) begin
          state_nxt = S_DRAIN;
          drain_nxt = 2'd2;
        end
      end
      S_DRAIN: begin
        if (drain_r == 2'd0) begin
          fin_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          drain_nxt = drain_r - 2'd1;
        end
      end
      S_READ: begin
        if (!rd_r) begin
          rd_nxt = 1'b1;
        end else begin
          fin_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end
        ctl.rd = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
    ctl.rd_done = fin_r;
  end

  assign busy = (state_r != S_IDLE) || fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      drain_r <= 2'd0;
      rd_r    <= 1'b0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
      rd_r    <= rd_nxt;
      fin_r   <= fin_nxt;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/rdbf_dp.sv
// ----------------------------------------------------------------------------
// rdbf_dp
// scan counters, circle test, blend pipeline and frame memory
// ----------------------------------------------------------------------------
`default_nettype none
module rdbf_dp #(
  parameter int MAX_WIDTH  = rdbf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rdbf_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire rdbf_pkg::ctl_t            ctl,
  input  wire rdbf_pkg::in_item_t        in_item,
  input  wire logic [rdbf_pkg::DIM_W-1:0] width_cfg,
  input  wire logic [rdbf_pkg::DIM_W-1:0] height_cfg,
  output rdbf_pkg::sts_t                 sts,
  output rdbf_pkg::out_item_t            out_item
);
  import rdbf_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int XAW   = (XW < 1) ? 1 : XW;
  localparam int YAW   = (YW < 1) ? 1 : YW;
  localparam int DEPTH = (1 << XW) * (1 << YW);
  localparam int AW    = XW + YW;
  localparam int RAW   = (AW < 1) ? 1 : AW;
  localparam int CW    = 14;  // coordinate in pixels, signed

  in_item_t        it_r;
  logic [1:0]      mode_r;
  logic signed [CW-1:0] x0_r, x1_r, y0_r, y1_r;
  logic signed [CW-1:0] px_r, py_r;
  logic [23:0]     r2_r;

  // box from center and radius
  logic signed [17:0] fr, lox, hix, loy, hiy;
  logic signed [CW-1:0] bx0, bx1, by0, by1;
  logic [DIM_W-1:0] uw, uh;

  assign uw = (32'(width_cfg)  > 32'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : width_cfg;
  assign uh = (32'(height_cfg) > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_cfg;

  always_comb begin
    fr  = 18'(in_item.dab_radius) + 18'sd16;
    lox = 18'(in_item.center_x) - fr;
    hix = 18'(in_item.center_x) + fr + 18'sd15;
    loy = 18'(in_item.center_y) - fr;
    hiy = 18'(in_item.center_y) + fr + 18'sd15;
    // arithmetic shift gives floor; +15 then shift gives ceil
    bx0 = CW'(lox >>> 4);
    bx1 = CW'(hix >>> 4);
    by0 = CW'(loy >>> 4);
    by1 = CW'(hiy >>> 4);
    if (in_item.cmd != CMD_DAB) begin
      bx0 = '0;
      by0 = '0;
      bx1 = CW'(uw);
      by1 = CW'(uh);
    end
    if (bx0 < 0) bx0 = '0;
    if (by0 < 0) by0 = '0;
    if (bx1 > $signed(CW'(uw))) bx1 = CW'(uw);
    if (by1 > $signed(CW'(uh))) by1 = CW'(uh);
  end

  assign sts.box_empty = (x0_r >= x1_r) || (y0_r >= y1_r);
  assign sts.last      = (px_r == x1_r - 1) && (py_r == y1_r - 1);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      it_r   <= in_item;
      mode_r <= in_item.cmd;
      x0_r   <= bx0;
      x1_r   <= bx1;
      y0_r   <= by0;
      y1_r   <= by1;
      px_r   <= bx0;
      py_r   <= by0;
      r2_r   <= 24'(in_item.dab_radius) * 24'(in_item.dab_radius);
    end else if (ctl.step) begin
      if (px_r == x1_r - 1) begin
        px_r <= x0_r;
        py_r <= py_r + 1'b1;
      end else begin
        px_r <= px_r + 1'b1;
      end
    end
  end

  // stage 1: offsets and squares
  logic signed [17:0] dx, dy;
  logic [33:0] dx2_r, dy2_r;
  logic        s1_v_r;
  logic [XAW-1:0] s1_x_r;
  logic [YAW-1:0] s1_y_r;
  assign dx = ($signed(18'(px_r)) <<< 4) + 18'sd8 - 18'(it_r.center_x);
  assign dy = ($signed(18'(py_r)) <<< 4) + 18'sd8 - 18'(it_r.center_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= ctl.walk;
    end
    dx2_r  <= 34'(dx * dx);
    dy2_r  <= 34'(dy * dy);
    s1_x_r <= XAW'(px_r);
    s1_y_r <= YAW'(py_r);
  end

  // stage 2: inside test, memory read returns
  logic [RAW-1:0] rd_addr, wr_addr;
  logic [PIX_W-1:0] rdata;
  logic        s2_v_r, s2_in_r;
  logic [XAW-1:0] s2_x_r;
  logic [YAW-1:0] s2_y_r;

  function automatic logic [RAW-1:0] addr_of(input logic [XAW-1:0] x,
                                             input logic [YAW-1:0] y);
    logic [RAW-1:0] a;
    a = '0;
    if (XW > 0) a = RAW'(x);
    if (YW > 0) a = a | RAW'(RAW'(y) << XW);
    return a;
  endfunction

  always_comb begin
    if (ctl.rd) begin
      rd_addr = addr_of(XAW'(it_r.pixel_x), YAW'(it_r.pixel_y));
    end else begin
      rd_addr = addr_of(s1_x_r, s1_y_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_in_r <= (35'(dx2_r) + 35'(dy2_r)) < 35'(r2_r);
    s2_x_r  <= s1_x_r;
    s2_y_r  <= s1_y_r;
  end

  // blend with read data, write back
  function automatic logic [7:0] mix(input logic [8:0] op, input logic [7:0] c,
                                     input logic [7:0] old);
    logic [17:0] s;
    s = 18'(op * c) + 18'((9'd256 - op) * old);
    return s[15:8];
  endfunction

  logic [8:0]  opc;
  logic [7:0]  pat_b;
  logic [15:0] sq;
  logic [7:0]  ux, uy;
  logic [PIX_W-1:0] wdata;
  logic        we;

  assign opc = (it_r.opacity > 9'd256) ? 9'd256 : it_r.opacity;
  assign ux  = 8'(s2_x_r);
  assign uy  = 8'(s2_y_r);
  assign sq  = 16'(ux * ux) + 16'(uy * uy);
  assign pat_b = sq[7:0];

  always_comb begin
    we      = 1'b0;
    wdata   = '0;
    wr_addr = addr_of(s2_x_r, s2_y_r);
    case (mode_r)
      CMD_CLEAR: begin
        we    = s2_v_r;
        wdata = 24'hFFFFFF;
      end
      CMD_PATTERN: begin
        we    = s2_v_r;
        wdata = {ux, uy, pat_b};
      end
      CMD_DAB: begin
        we    = s2_v_r && s2_in_r;
        wdata = {mix(opc, it_r.brush_red,   rdata[23:16]),
                 mix(opc, it_r.brush_green, rdata[15:8]),
                 mix(opc, it_r.brush_blue,  rdata[7:0])};
      end
      default: we = 1'b0;
    endcase
  end

  rdbf_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  logic in_range;
  assign in_range = (32'(it_r.pixel_x) < 32'(MAX_WIDTH)) &&
                    (32'(it_r.pixel_y) < 32'(MAX_HEIGHT));

  always_comb begin
    out_item = '0;
    if (ctl.rd_done && mode_r == CMD_READ && in_range) begin
      out_item = rdata;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/round_dab_blend_framebuffer.sv
// ----------------------------------------------------------------------------
// round_dab_blend_framebuffer
// rgb framebuffer with clear, test pattern, round dab blend and pixel read
// ----------------------------------------------------------------------------
// usage
//   - a command transfer happens when in_start is high and in_busy is low;
//     the whole item sits on in_item
//   - every command gives one result: out_valid pulses for one cycle with
//     out_item (pixel for read, zero otherwise); the receiver cannot stall
//   - clear and pattern go to the result through a setup state, a walk of
//     one pixel per cycle over width*height, a drain state and the result
//   - a dab walks box_width*box_height pixels likewise, the box being the
//     whole pixels within radius + 1 pixel of the center, clamped to the
//     surface; the single frame ram port pair (read for blend, write back)
//     sets the one pixel per cycle pace; an empty box or surface skips the walk
//   - a read returns the pixel at pixel_x, pixel_y from the registered ram read
//   - in_busy stays high through the result cycle, so the next command
//     transfer comes in the cycle after the result at the earliest
//   - surface size is written over the cfg apb port while idle:
//     0x0 width, 0x4 height; reset value 256 each
//   - frame memory content is undefined after reset; clear or pattern first
//   - rst_n is synchronous, active low
// ----------------------------------------------------------------------------
`default_nettype none
module round_dab_blend_framebuffer #(
  parameter int MAX_WIDTH  = rdbf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rdbf_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_start,
  output logic                             in_busy,
  input  wire rdbf_pkg::in_item_t          in_item,
  output logic                             out_valid,
  output rdbf_pkg::out_item_t              out_item,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [rdbf_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output logic      [31:0]                 cfg_prdata,
  output logic                             cfg_pready
);
  import rdbf_pkg::*;

  logic [DIM_W-1:0] width_r, height_r;
  ctl_t ctl;
  sts_t sts;

  // config registers, written on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(256);
      height_r <= DIM_W'(256);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr)
        ADDR_WIDTH:  width_r  <= cfg_pwdata[DIM_W-1:0];
        ADDR_HEIGHT: height_r <= cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (cfg_paddr)
      ADDR_WIDTH:  cfg_prdata = 32'(width_r);
      ADDR_HEIGHT: cfg_prdata = 32'(height_r);
      default:     cfg_prdata = '0;
    endcase
  end

  rdbf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_start),
    .cmd   (in_item.cmd),
    .sts   (sts),
    .busy  (in_busy),
    .ctl   (ctl)
  );

  rdbf_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .in_item    (in_item),
    .width_cfg  (width_r),
    .height_cfg (height_r),
    .sts        (sts),
    .out_item   (out_item)
  );

  // one result transfer per command
  assign out_valid = ctl.rd_done;
endmodule
`default_nettype wire

// File: sim/rdbf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdbf_checker
// watches the command, result and cfg channels of the dab framebuffer,
// keeps its own copy of the surface and compares every result transfer
// ----------------------------------------------------------------------------
module rdbf_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_start,
  input  logic                in_busy,
  input  rdbf_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  rdbf_pkg::out_item_t out_item,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  input  logic                cfg_pready,
  output int                  fail_count
);
  import rdbf_pkg::*;

  localparam int MW = DEF_MAX_WIDTH;
  localparam int MH = DEF_MAX_HEIGHT;

  logic [23:0] shadow_fb [MW*MH];
  logic [8:0]  surf_w, surf_h;
  out_item_t   pixel_q [$];

  function automatic int used_w();
    return (surf_w > MW) ? MW : int'(surf_w);
  endfunction

  function automatic int used_h();
    return (surf_h > MH) ? MH : int'(surf_h);
  endfunction

  function automatic logic [7:0] blend(int op, int c, int old);
    return 8'((op * c + (256 - op) * old) >> 8);
  endfunction

  task automatic paint_dab(in_item_t it);
    int cx, cy, rad, op, fr, x0, x1, y0, y1, px, py;
    longint dx, dy, r2;
    logic [23:0] old;
    cx = it.center_x;
    cy = it.center_y;
    rad = it.dab_radius;
    op = (it.opacity > 256) ? 256 : int'(it.opacity);
    fr = rad + 16;
    x0 = (cx - fr) >>> 4;
    y0 = (cy - fr) >>> 4;
    x1 = -((-(cx + fr)) >>> 4);
    y1 = -((-(cy + fr)) >>> 4);
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > used_w()) x1 = used_w();
    if (y1 > used_h()) y1 = used_h();
    r2 = longint'(rad) * rad;
    for (py = y0; py < y1; py++) begin
      dy = longint'(py) * 16 + 8 - cy;
      for (px = x0; px < x1; px++) begin
        dx = longint'(px) * 16 + 8 - cx;
        if (dx * dx + dy * dy < r2) begin
          old = shadow_fb[py*MW + px];
          shadow_fb[py*MW + px] = {blend(op, it.brush_red, old[23:16]),
                                   blend(op, it.brush_green, old[15:8]),
                                   blend(op, it.brush_blue, old[7:0])};
        end
      end
    end
  endtask

  task automatic predict_pixel(in_item_t it);
    out_item_t exp_px;
    int x, y;
    exp_px = '0;
    case (cmd_t'(it.cmd))
      CMD_CLEAR: begin
        for (y = 0; y < used_h(); y++)
          for (x = 0; x < used_w(); x++)
            shadow_fb[y*MW + x] = 24'hFFFFFF;
      end
      CMD_PATTERN: begin
        for (y = 0; y < used_h(); y++)
          for (x = 0; x < used_w(); x++)
            shadow_fb[y*MW + x] = {8'(x), 8'(y), 8'(x*x + y*y)};
      end
      CMD_DAB: paint_dab(it);
      default: begin
        if (it.pixel_x < MW && it.pixel_y < MH)
          exp_px = shadow_fb[it.pixel_y*MW + it.pixel_x];
      end
    endcase
    pixel_q.push_back(exp_px);
  endtask

  always @(posedge clk) begin
    out_item_t exp_px;
    if (!rst_n) begin
      surf_w <= 9'd256;
      surf_h <= 9'd256;
      fail_count <= 0;
      pixel_q.delete();
    end else begin
      if (out_valid) begin
        if (pixel_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_px = pixel_q.pop_front();
          if (out_item !== exp_px) begin
            if (out_item.read_red !== exp_px.read_red)
              $error("read_red exp %0d got %0d", exp_px.read_red, out_item.read_red);
            if (out_item.read_green !== exp_px.read_green)
              $error("read_green exp %0d got %0d", exp_px.read_green, out_item.read_green);
            if (out_item.read_blue !== exp_px.read_blue)
              $error("read_blue exp %0d got %0d", exp_px.read_blue, out_item.read_blue);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_start && !in_busy) predict_pixel(in_item);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == ADDR_WIDTH) surf_w <= cfg_pwdata[8:0];
        else if (cfg_paddr == ADDR_HEIGHT) surf_h <= cfg_pwdata[8:0];
      end
    end
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives clear, pattern, dab and read commands and surface size writes into
// the dab framebuffer; the checker predicts every result and counts misses
// ----------------------------------------------------------------------------
module tb;
  import rdbf_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_start;
  logic        in_busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int          fail_count;

  // command and result transfer counts, to know when the block is idle
  int cmds_sent;
  int pixels_back;

  // surface size as the stimulus sees it, saturated like the block
  int cur_w, cur_h;
  // sender idle chance in percent
  int idle_pct;

  round_dab_blend_framebuffer uut (
    .clk, .rst_n, .in_start, .in_busy, .in_item, .out_valid, .out_item,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  rdbf_checker chk (
    .clk, .rst_n, .in_start, .in_busy, .in_item, .out_valid, .out_item,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #50ms;
    $display("[round_dab_blend_framebuffer] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) pixels_back <= 0;
    else if (out_valid) pixels_back <= pixels_back + 1;
  end

  // one command transfer; in_start stays high afterwards so back to back
  // commands never drop it, the sender lowers it only when it idles
  task automatic send_cmd(in_item_t it);
    in_start <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_busy);
    cmds_sent++;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // hold off until every result transfer is back, then a few spare cycles
  task automatic drain();
    in_start <= 1'b0;
    @(posedge clk);
    while (pixels_back != cmds_sent) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // apb write: setup cycle then access cycle, then back to idle
  task automatic reg_write(logic [2:0] addr, int val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_surface(int w, int h);
    drain();
    reg_write(ADDR_WIDTH, w);
    reg_write(ADDR_HEIGHT, h);
    cur_w = ((w & 511) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : (w & 511);
    cur_h = ((h & 511) > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : (h & 511);
  endtask

  function automatic in_item_t mk_cmd(cmd_t c);
    in_item_t it;
    logic [127:0] rnd;
    rnd = {$urandom, $urandom, $urandom, $urandom};
    it = in_item_t'(rnd[$bits(in_item_t)-1:0]);
    it.cmd = c;
    return it;
  endfunction

  function automatic in_item_t mk_dab(int cx, int cy, int r, int op,
                                      logic [7:0] cr, logic [7:0] cg, logic [7:0] cb);
    in_item_t it;
    it = mk_cmd(CMD_DAB);
    it.center_x = 16'(cx);
    it.center_y = 16'(cy);
    it.dab_radius = 12'(r);
    it.opacity = 9'(op);
    it.brush_red = cr;
    it.brush_green = cg;
    it.brush_blue = cb;
    return it;
  endfunction

  function automatic in_item_t mk_read(int x, int y);
    in_item_t it;
    it = mk_cmd(CMD_READ);
    it.pixel_x = 8'(x);
    it.pixel_y = 8'(y);
    return it;
  endfunction

  // random command with content aimed at the surface in use
  function automatic in_item_t rand_cmd();
    in_item_t it;
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) begin
      it = mk_cmd(CMD_CLEAR);
    end else if (sel < 16) begin
      it = mk_cmd(CMD_PATTERN);
    end else if (sel < 60) begin
      it = mk_cmd(CMD_DAB);
      // mostly centered near the surface with moderate radius
      if ($urandom_range(99) < 80) begin
        it.center_x = 16'(int'($urandom_range(0, cur_w*16 + 128)) - 64);
        it.center_y = 16'(int'($urandom_range(0, cur_h*16 + 128)) - 64);
      end
      if ($urandom_range(99) < 75) it.dab_radius = 12'($urandom_range(0, 200));
    end else begin
      // every entry was cleared after reset, so any pixel is fair game
      if (cur_w > 0 && cur_h > 0 && $urandom_range(99) < 80)
        it = mk_read($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1));
      else
        it = mk_cmd(CMD_READ);
    end
    return it;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_cmd(rand_cmd());
  endtask

  initial begin
    rst_n       = 1'b0;
    in_start    = 1'b0;
    in_item     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    cmds_sent   = 0;
    cur_w       = DEF_MAX_WIDTH;
    cur_h       = DEF_MAX_HEIGHT;
    idle_pct    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full surface at reset size, clear first so no read is unwritten
    send_cmd(mk_cmd(CMD_CLEAR));
    send_cmd(mk_read(0, 0));
    send_cmd(mk_read(255, 255));
    send_cmd(mk_cmd(CMD_PATTERN));
    send_cmd(mk_read(255, 255));
    send_cmd(mk_read(3, 200));
    // pixel-center circle boundary: only (0,0) strictly inside
    send_cmd(mk_dab(8, 8, 16, 256, 8'hFF, 8'h00, 8'hAA));
    send_cmd(mk_read(0, 0));
    send_cmd(mk_read(1, 0));
    send_cmd(mk_read(0, 1));
    // radius zero blends nothing
    send_cmd(mk_dab(40, 40, 0, 256, 8'h00, 8'h00, 8'h00));
    send_cmd(mk_read(2, 2));
    // opacity zero, opacity saturating above 256
    send_cmd(mk_dab(100, 100, 48, 0, 8'h12, 8'h34, 8'h56));
    send_cmd(mk_read(6, 6));
    send_cmd(mk_dab(100, 100, 48, 511, 8'h12, 8'h34, 8'h56));
    send_cmd(mk_read(6, 6));
    // boxes that miss the surface entirely
    send_cmd(mk_dab(-32768, -32768, 4095, 128, 8'hFF, 8'hFF, 8'hFF));
    send_cmd(mk_dab(32767, 32767, 4095, 128, 8'h00, 8'hFF, 8'h00));
    // largest radius over the whole surface
    send_cmd(mk_dab(2048, 2048, 4095, 200, 8'h80, 8'h40, 8'hC0));
    send_cmd(mk_read(128, 128));
    send_cmd(mk_read(255, 0));

    // pause until everything is back, then size extremes
    set_surface(0, 5);   // empty surface: nothing gets written
    send_cmd(mk_cmd(CMD_CLEAR));
    send_cmd(mk_dab(0, 0, 300, 256, 8'h00, 8'h00, 8'h00));
    send_cmd(mk_read(0, 0));
    set_surface(511, 2); // width saturates to the maximum
    send_cmd(mk_cmd(CMD_CLEAR));
    send_cmd(mk_read(255, 1));
    send_cmd(mk_read(10, 2));

    // random phases, sender idling 10 percent, then 85, then never
    idle_pct = 10;
    set_surface(16, 12);  run_random(60);
    set_surface(1, 1);    run_random(30);
    set_surface(300, 3);  run_random(40);
    idle_pct = 85;
    set_surface(33, 20);  run_random(70);
    set_surface(1, 256);  run_random(30);
    set_surface(0, 0);    run_random(20);
    set_surface(24, 31);  run_random(60);
    idle_pct = 0;
    set_surface(256, 1);  run_random(50);
    set_surface(9, 40);   run_random(60);
    set_surface(32, 32);  run_random(60);

    drain();
    if (fail_count == 0 && pixels_back == cmds_sent)
      $display("[round_dab_blend_framebuffer] OK");
    else
      $display("[round_dab_blend_framebuffer] ERROR");
    $finish;
  end

endmodule
